[rtl/core/skf_pkg.sv]
package skf_pkg;

    // Fractional bits of variance, noise and gain words.
    localparam int FRAC_BITS_VAR = 30;

    localparam int DATA_W  = 32;
    localparam int VAR_W   = 32;
    localparam int GAIN_W  = FRAC_BITS_VAR + 1;      // gain spans 0 .. 1.0 inclusive
    localparam int INNOV_W = DATA_W + 1;
    localparam int PROD_W  = INNOV_W + GAIN_W + 1;
    localparam int STEP_W  = $clog2(GAIN_W);

    localparam longint unsigned VAR_ONE_L = 64'd1 << FRAC_BITS_VAR;

    localparam logic [VAR_W-1:0]  VAR_ONE  = VAR_W'(VAR_ONE_L);
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(VAR_ONE_L);
    localparam logic [VAR_W-1:0]  Q_RESET  = VAR_W'((VAR_ONE_L + 64'd5000) / 64'd10000);
    localparam logic [VAR_W-1:0]  R_RESET  = VAR_W'((VAR_ONE_L + 64'd50) / 64'd100);

    // Configuration register indexes
    localparam logic REG_PROCESS_NOISE     = 1'b0;
    localparam logic REG_MEASUREMENT_NOISE = 1'b1;

endpackage

[rtl/core/scalar_kalman_filter_unit.sv]
// Scalar Kalman filter (random-walk model). Each measurement transfer on the
// slave side yields one estimate transfer on the master side. An item passes
// through prediction, the gain division, the estimate update and the variance
// update before its estimate is registered, and the next measurement is taken
// only once that item is through: the gain comes from a bit-serial divider
// that yields one quotient bit per cycle, and one shared multiplier then
// forms the estimate step and the new variance in turn. s_tready is high only
// while no item is in work; a finished estimate may wait in the output
// register while the next measurement is taken. Write configuration only
// while idle.
module scalar_kalman_filter_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_addr,
    input  logic [skf_pkg::VAR_W-1:0]  cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [skf_pkg::DATA_W-1:0] s_tdata,   // [31:0] measurement
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [skf_pkg::DATA_W-1:0] m_tdata    // [31:0] estimate
);
    import skf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_MULX,
        ST_UPDX,
        ST_MULP,
        ST_UPDP,
        ST_FIN
    } state_t;

    state_t                     state_reg;
    logic [VAR_W-1:0]           q_reg;
    logic [VAR_W-1:0]           r_reg;
    logic signed [DATA_W-1:0]   est_reg;
    logic [VAR_W-1:0]           var_reg;
    logic signed [DATA_W-1:0]   z_reg;
    logic signed [INNOV_W-1:0]  innov_reg;
    logic [VAR_W-1:0]           pp_reg;
    logic [GAIN_W-1:0]          k_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [DATA_W-1:0]          out_reg;
    logic                       out_valid_reg;

    logic [VAR_W:0]             pp_sum;
    logic [VAR_W-1:0]           pp_next;
    logic signed [INNOV_W-1:0]  innov_next;
    logic signed [INNOV_W-1:0]  mul_a;
    logic [GAIN_W-1:0]          mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [DATA_W-1:0]          prod_scaled;
    logic                       div_start;
    logic                       div_done;
    logic [GAIN_W-1:0]          div_q;
    logic                       out_free;

    skf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .pp       (pp_reg),
        .noise    (r_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // predicted variance saturates at all ones
    assign pp_sum     = {1'b0, var_reg} + {1'b0, q_reg};
    assign pp_next    = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
    assign innov_next = {z_reg[DATA_W-1], z_reg} - {est_reg[DATA_W-1], est_reg};

    // shared multiplier: innovation * K, then pp * (1 - K)
    always_comb
    begin
        if (state_reg == ST_MULX)
        begin
            mul_a = innov_reg;
            mul_b = k_reg;
        end
        else
        begin
            mul_a = {1'b0, pp_reg};
            mul_b = GAIN_ONE - k_reg;
        end
    end

    assign mul_p       = PROD_W'(mul_a) * $signed({1'b0, mul_b});
    assign prod_scaled = prod_reg[FRAC_BITS_VAR +: DATA_W];   // floor(prod / 2^F)

    assign div_start = state_reg == ST_DIVGO;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = state_reg == ST_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            q_reg         <= Q_RESET;
            r_reg         <= R_RESET;
            est_reg       <= '0;
            var_reg       <= VAR_ONE;
            z_reg         <= '0;
            innov_reg     <= '0;
            pp_reg        <= '0;
            k_reg         <= '0;
            prod_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_PROCESS_NOISE:     q_reg <= cfg_wdata;
                    REG_MEASUREMENT_NOISE: r_reg <= cfg_wdata;
                    default:               ;
                endcase
            end

            // in ST_FIN the output register is reloaded below
            if (out_valid_reg && m_tready && (state_reg != ST_FIN))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        z_reg     <= s_tdata;
                        state_reg <= ST_PRED;
                    end
                end
                ST_PRED:
                begin
                    pp_reg    <= pp_next;
                    innov_reg <= innov_next;
                    state_reg <= ST_DIVGO;
                end
                ST_DIVGO:
                begin
                    state_reg <= ST_DIVWAIT;
                end
                ST_DIVWAIT:
                begin
                    if (div_done)
                    begin
                        k_reg     <= div_q;
                        state_reg <= ST_MULX;
                    end
                end
                ST_MULX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_UPDX;
                end
                ST_UPDX:
                begin
                    est_reg   <= est_reg + prod_scaled;
                    state_reg <= ST_MULP;
                end
                ST_MULP:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_UPDP;
                end
                ST_UPDP:
                begin
                    var_reg   <= prod_scaled;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg       <= est_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/skf_div.sv]
// Radix-2 restoring divider for the gain: quotient = floor(pp * 2^F / (pp + noise)).
// One integer step and F fractional steps, one per cycle.
module skf_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [skf_pkg::VAR_W-1:0] pp,
    input  logic [skf_pkg::VAR_W-1:0] noise,
    output logic                      done,
    output logic [skf_pkg::GAIN_W-1:0] quotient
);
    import skf_pkg::*;

    logic [VAR_W+1:0]  rem_reg;
    logic [VAR_W:0]    den_reg;
    logic [GAIN_W-1:0] quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              zero_reg;

    logic              take;
    logic [VAR_W+1:0]  diff;
    logic [VAR_W+1:0]  rem_kept;

    assign take     = rem_reg >= {1'b0, den_reg};
    assign diff     = rem_reg - {1'b0, den_reg};
    assign rem_kept = take ? diff : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= {2'b00, pp};
                den_reg  <= {1'b0, pp} + {1'b0, noise};
                zero_reg <= (pp == '0) && (noise == '0);
                quo_reg  <= '0;
                cnt_reg  <= STEP_W'(GAIN_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // remainder stays below den, so the shift fits
                rem_reg <= {rem_kept[VAR_W:0], 1'b0};
                quo_reg <= {quo_reg[GAIN_W-2:0], take};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : quo_reg;

endmodule
